// ===== src/mcrqd_pkg.sv =====
// ----------------------------------------------------------------------------
// mcrqd_pkg
// Shared types, widths and codes of the multi-CPU ready-queue dispatcher.
// ----------------------------------------------------------------------------
package mcrqd_pkg;

  localparam int MAX_PROCS = 16;
  localparam int MAX_CPUS  = 8;

  localparam int KIND_W  = 3;
  localparam int CPU_W   = 3;
  localparam int ID_W    = 4;
  localparam int PRIO_W  = 8;
  localparam int ACT_W   = 2;
  localparam int SLICE_W = 8;
  localparam int MODE_W  = 2;
  localparam int CPUS_W  = 4;

  localparam int QPTR_W  = $clog2(MAX_PROCS);
  localparam int QCNT_W  = $clog2(MAX_PROCS + 1);
  localparam int ENTRY_W = ID_W + PRIO_W;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_SCHEDULE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PREEMPT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_YIELD     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TERMINATE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WAKE      = 3'd4;

  // Result actions
  localparam logic [ACT_W-1:0] ACT_RUN     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_IDLE    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PREEMPT = 2'd2;

  // Scheduling modes
  localparam logic [MODE_W-1:0] MODE_FIFO     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RR       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PRIORITY = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLICE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CPUS  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SLICE_W-1:0] slice_ticks;
    logic [CPUS_W-1:0]  cpus_in_use;
  } cfg_t;

endpackage

// ===== src/mcrqd_if.sv =====
// ----------------------------------------------------------------------------
// mcrqd_if
// Valid/ready channels of the dispatcher: scheduler events in, results out.
// ----------------------------------------------------------------------------
interface mcrqd_in_if;
  import mcrqd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CPU_W-1:0]  cpu;
  logic [ID_W-1:0]   proc_id;
  logic [PRIO_W-1:0] proc_priority;

  modport source (output valid, kind, cpu, proc_id, proc_priority, input ready);
  modport sink   (input valid, kind, cpu, proc_id, proc_priority, output ready);
endinterface

interface mcrqd_out_if;
  import mcrqd_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [CPU_W-1:0]   target_cpu;
  logic [ID_W-1:0]    run_id;
  logic [SLICE_W-1:0] slice_out;

  modport source (output valid, action, target_cpu, run_id, slice_out, input ready);
  modport sink   (input valid, action, target_cpu, run_id, slice_out, output ready);
endinterface

// ===== src/mcrqd_ram.sv =====
// ----------------------------------------------------------------------------
// mcrqd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcrqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mcrqd_cfg.sv =====
// ----------------------------------------------------------------------------
// mcrqd_cfg
// APB-style register block holding mode, time slice and CPU count.
// ----------------------------------------------------------------------------
module mcrqd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mcrqd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mcrqd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mcrqd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready,
  output mcrqd_pkg::cfg_t                  cfg
);
  import mcrqd_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:  cfg_nxt.mode        = pwdata[MODE_W-1:0];
        REG_SLICE: cfg_nxt.slice_ticks = pwdata[SLICE_W-1:0];
        REG_CPUS:  cfg_nxt.cpus_in_use = pwdata[CPUS_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:  prdata = CFG_DATA_W'(cfg_r.mode);
      REG_SLICE: prdata = CFG_DATA_W'(cfg_r.slice_ticks);
      REG_CPUS:  prdata = CFG_DATA_W'(cfg_r.cpus_in_use);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_FIFO;
      cfg_r.slice_ticks <= '0;
      cfg_r.cpus_in_use <= CPUS_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/mcrqd_core.sv =====
// ----------------------------------------------------------------------------
// mcrqd_core
// Event sequencer: ready queue, per-CPU state and the shared priority
// comparator that scans the CPUs one at a time.
// ----------------------------------------------------------------------------
module mcrqd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  mcrqd_pkg::cfg_t cfg,
  mcrqd_in_if.sink        in_ch,
  mcrqd_out_if.source     out_ch
);
  import mcrqd_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DECODE   = 9'b000000010,
    ST_SCAN_RD  = 9'b000000100,
    ST_SCAN_CMP = 9'b000001000,
    ST_PRE_RD   = 9'b000010000,
    ST_PRE_WR   = 9'b000100000,
    ST_DISPATCH = 9'b001000000,
    ST_DISP_WR  = 9'b010000000,
    ST_EMIT     = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;

  // Accepted event
  logic [KIND_W-1:0]   kind_r;
  logic [CPU_W-1:0]    cpu_r;
  logic [ID_W-1:0]     id_r;
  logic [PRIO_W-1:0]   prio_r;

  // Queue pointers and CPU busy flags
  logic [QPTR_W-1:0]   head_r, head_nxt;
  logic [QPTR_W-1:0]   tail_r, tail_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic [MAX_CPUS-1:0] busy_r, busy_nxt;

  // Scan state
  logic [CPU_W-1:0]    idx_r, idx_nxt;
  logic [PRIO_W-1:0]   best_r, best_nxt;
  logic [CPU_W-1:0]    chosen_r, chosen_nxt;
  logic                found_r, found_nxt;

  // Pending result and output register
  logic [ACT_W-1:0]    res_act_r, res_act_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic [CPU_W-1:0]    res_cpu_r, res_cpu_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0]    out_act_r;
  logic [CPU_W-1:0]    out_cpu_r;
  logic [ID_W-1:0]     out_id_r;
  logic [SLICE_W-1:0]  out_slice_r;
  logic                out_load;

  // Memory ports
  logic                q_we;
  logic [ENTRY_W-1:0]  q_wdata, q_rdata;
  logic                run_we;
  logic [CPU_W-1:0]    run_raddr;
  logic [ENTRY_W-1:0]  run_rdata;

  logic [CPUS_W-1:0]   n_eff;
  logic                q_full;
  logic                last_cpu;
  logic                less_prio;
  logic                accept;

  always_comb begin
    if (cfg.cpus_in_use == '0) begin
      n_eff = CPUS_W'(1);
    end else if (cfg.cpus_in_use > CPUS_W'(MAX_CPUS)) begin
      n_eff = CPUS_W'(MAX_CPUS);
    end else begin
      n_eff = cfg.cpus_in_use;
    end
  end

  assign q_full    = (count_r == QCNT_W'(MAX_PROCS));
  assign last_cpu  = ((CPUS_W'(idx_r) + CPUS_W'(1)) == n_eff);
  // The one comparator shared by every step of the wake-up scan.
  assign less_prio = (run_rdata[PRIO_W-1:0] < best_r);
  assign run_raddr = (state_r == ST_SCAN_RD) ? idx_r : cpu_r;
  assign accept    = in_ch.valid && in_ch.ready;
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.action     = out_act_r;
  assign out_ch.target_cpu = out_cpu_r;
  assign out_ch.run_id     = out_id_r;
  assign out_ch.slice_out  = out_slice_r;

  mcrqd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PROCS)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (q_wdata),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  mcrqd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CPUS)) u_run_ram (
    .clk   (clk),
    .we    (run_we),
    .waddr (cpu_r),
    .wdata (q_rdata),
    .raddr (run_raddr),
    .rdata (run_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    busy_nxt    = busy_r;
    idx_nxt     = idx_r;
    best_nxt    = best_r;
    chosen_nxt  = chosen_r;
    found_nxt   = found_r;
    res_act_nxt = res_act_r;
    res_id_nxt  = res_id_r;
    res_cpu_nxt = res_cpu_r;
    q_we        = 1'b0;
    q_wdata     = {id_r, prio_r};
    run_we      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (kind_r == KIND_WAKE) begin
          q_we = !q_full;
          if (cfg.mode == MODE_PRIORITY) begin
            idx_nxt   = '0;
            best_nxt  = prio_r;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (kind_r > KIND_WAKE || CPUS_W'(cpu_r) >= n_eff) begin
          state_nxt = ST_IDLE;
        end else if (kind_r == KIND_PREEMPT) begin
          state_nxt = busy_r[cpu_r] ? ST_PRE_RD : ST_DISPATCH;
        end else begin
          if (kind_r == KIND_YIELD || kind_r == KIND_TERMINATE) begin
            busy_nxt[cpu_r] = 1'b0;
          end
          state_nxt = ST_DISPATCH;
        end
      end

      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        if (!busy_r[idx_r]) begin
          // A free CPU ends the scan at once.
          chosen_nxt  = idx_r;
          res_act_nxt = ACT_PREEMPT;
          res_cpu_nxt = idx_r;
          res_id_nxt  = '0;
          state_nxt   = ST_EMIT;
        end else begin
          if (less_prio) begin
            best_nxt   = run_rdata[PRIO_W-1:0];
            chosen_nxt = idx_r;
            found_nxt  = 1'b1;
          end
          if (last_cpu) begin
            res_act_nxt = ACT_PREEMPT;
            res_cpu_nxt = less_prio ? idx_r : chosen_r;
            res_id_nxt  = '0;
            state_nxt   = (found_r || less_prio) ? ST_EMIT : ST_IDLE;
          end else begin
            idx_nxt   = idx_r + CPU_W'(1);
            state_nxt = ST_SCAN_RD;
          end
        end
      end

      ST_PRE_RD: begin
        state_nxt = ST_PRE_WR;
      end

      ST_PRE_WR: begin
        q_we            = !q_full;
        q_wdata         = run_rdata;
        busy_nxt[cpu_r] = 1'b0;
        state_nxt       = ST_DISPATCH;
      end

      ST_DISPATCH: begin
        res_cpu_nxt = cpu_r;
        if (busy_r[cpu_r]) begin
          state_nxt = ST_IDLE;
        end else if (count_r == '0) begin
          res_act_nxt = ACT_IDLE;
          res_id_nxt  = '0;
          state_nxt   = ST_EMIT;
        end else begin
          state_nxt = ST_DISP_WR;
        end
      end

      ST_DISP_WR: begin
        // The head entry read in the previous cycle becomes the running one.
        run_we          = 1'b1;
        busy_nxt[cpu_r] = 1'b1;
        head_nxt        = (head_r == QPTR_W'(MAX_PROCS - 1)) ? '0 : head_r + QPTR_W'(1);
        count_nxt       = count_r - QCNT_W'(1);
        res_act_nxt     = ACT_RUN;
        res_id_nxt      = q_rdata[ENTRY_W-1:PRIO_W];
        state_nxt       = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (q_we) begin
      tail_nxt  = (tail_r == QPTR_W'(MAX_PROCS - 1)) ? '0 : tail_r + QPTR_W'(1);
      count_nxt = count_r + QCNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      busy_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_ch.kind;
      cpu_r  <= in_ch.cpu;
      id_r   <= in_ch.proc_id;
      prio_r <= in_ch.proc_priority;
    end
    idx_r     <= idx_nxt;
    best_r    <= best_nxt;
    chosen_r  <= chosen_nxt;
    res_act_r <= res_act_nxt;
    res_id_r  <= res_id_nxt;
    res_cpu_r <= res_cpu_nxt;
    if (out_load) begin
      out_act_r   <= res_act_r;
      out_cpu_r   <= res_cpu_r;
      out_id_r    <= res_id_r;
      out_slice_r <= (res_act_r == ACT_PREEMPT) ? '0 : cfg.slice_ticks;
    end
  end

endmodule

// ===== src/multi_cpu_ready_queue_dispatcher.sv =====
// ----------------------------------------------------------------------------
// multi_cpu_ready_queue_dispatcher
// Ready-queue dispatcher for up to eight CPUs in fifo, round robin or static
// priority mode.
//
// Scheduler events arrive as words on in_ch (valid/ready) and each gives at
// most one result word on out_ch: run a process, run idle, or a preempt
// request. Mode, time slice and CPU count are written through the cfg_ APB
// port; the user must write them only while no event is in progress, which
// the block does not enforce. One event is handled at a time; in_ch.ready is
// high only while the sequencer is idle. A schedule, yield or terminate that
// dispatches from the queue goes through decode, dispatch and dispatch write;
// a preempt of a busy CPU adds preempt read and write, as the running process
// is read back and queued first. A priority-mode wake-up scans the n CPUs in
// use, whose state sits in a registered-read RAM; one comparator reads and
// compares each CPU in turn. Other wake-ups end in decode with no result.
// A result waits in the output register while out_ch stalls; the next event
// is still accepted and held back only when its own result is ready.
// Reset empties the queue, marks every CPU idle and sets fifo mode, a zero
// slice and one CPU.
// ----------------------------------------------------------------------------
module multi_cpu_ready_queue_dispatcher (
  input  logic                             clk,
  input  logic                             rst_n,
  mcrqd_in_if.sink                         in_ch,
  mcrqd_out_if.source                      out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [mcrqd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mcrqd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [mcrqd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import mcrqd_pkg::*;

  cfg_t cfg;

  mcrqd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mcrqd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
